### hdl/tred_pkg.sv
// ----------------------------------------------------------------------------
// tred_pkg
// Shared types and constants for the touch report event decoder.
// ----------------------------------------------------------------------------
package tred_pkg;

  localparam int COORD_W   = 10;
  localparam int KEY_SLOTS = 4;
  localparam int SLOT_W    = $clog2(KEY_SLOTS);
  localparam int HELD_W    = SLOT_W + 1;
  localparam int WIDTH_W   = 8;
  localparam int LEVEL_W   = 2;
  localparam int IN_DATA_W = 56;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [2:0] TYPE_RELEASE = 3'd0;
  localparam logic [2:0] TYPE_TOUCH   = 3'd1;
  localparam logic [1:0] KEY_UP_ONLY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THR = 1'b1;

  localparam logic [HELD_W-1:0] NO_KEY = HELD_W'(KEY_SLOTS);

  typedef enum logic [1:0] {
    KIND_POS = 2'd0,
    KIND_REL = 2'd1,
    KIND_KEY = 2'd2
  } event_kind_e;

  // one decoded frame, with an optional trailing key release
  typedef struct packed {
    logic                 two_res;
    event_kind_e          kind;
    logic [COORD_W-1:0]   pos_x;
    logic [COORD_W-1:0]   pos_y;
    logic [WIDTH_W-1:0]   width;
    logic [SLOT_W-1:0]    slot;
    logic [LEVEL_W-1:0]   level;
    logic [SLOT_W-1:0]    rel_slot;
  } tred_cmd_t;

endpackage

### hdl/tred_front.sv
// ----------------------------------------------------------------------------
// tred_front
// Accepts register frames, tracks touch and key state, queues decoded events.
// ----------------------------------------------------------------------------
module tred_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tred_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tred_pkg::COORD_W-1:0]     cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [tred_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output tred_pkg::tred_cmd_t              q_cmd_o
);
  import tred_pkg::*;

  logic                key_mode_q;
  logic [COORD_W-1:0]  move_thr_q;
  logic                first_q, first_d;
  logic [COORD_W-1:0]  prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic [HELD_W-1:0]   held_q, held_d;

  logic [7:0]          status, width_in, key_byte;
  logic [2:0]          in_type;
  logic [1:0]          key_up, key_state;
  logic [SLOT_W-1:0]   key_idx;
  logic [COORD_W-1:0]  x, y, dx, dy;
  logic                accept, has_res;
  tred_cmd_t           cmd;

  assign status   = s_axis_tdata[7:0];
  assign x        = {s_axis_tdata[9:8], s_axis_tdata[23:16]};
  assign y        = {s_axis_tdata[25:24], s_axis_tdata[39:32]};
  assign width_in = s_axis_tdata[47:40];
  assign key_byte = s_axis_tdata[55:48];
  assign in_type   = status[2:0];
  assign key_up    = status[7:6];
  assign key_state = key_byte[1:0];
  assign key_idx   = key_byte[3:2];

  assign dx = (x >= prev_x_q) ? (x - prev_x_q) : (prev_x_q - x);
  assign dy = (y >= prev_y_q) ? (y - prev_y_q) : (prev_y_q - y);

  assign s_axis_tready = !q_full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    first_d  = first_q;
    prev_x_d = prev_x_q;
    prev_y_d = prev_y_q;
    held_d   = held_q;
    has_res  = 1'b0;
    cmd      = '0;
    cmd.kind = KIND_POS;
    case (in_type)
      TYPE_TOUCH: begin
        if (first_q || dx >= move_thr_q || dy >= move_thr_q) begin
          has_res   = 1'b1;
          cmd.pos_x = x;
          cmd.pos_y = y;
          cmd.width = width_in;
          prev_x_d  = x;
          prev_y_d  = y;
          first_d   = 1'b0;
        end
      end
      TYPE_RELEASE: begin
        if (!key_mode_q) begin
          has_res   = 1'b1;
          cmd.kind  = KIND_REL;
          cmd.width = width_in;
          first_d   = 1'b1;
        end else if (key_state != 2'd0) begin
          if (held_q != {1'b0, key_idx}) begin
            has_res   = 1'b1;
            cmd.kind  = KIND_KEY;
            cmd.slot  = key_idx;
            cmd.level = key_state;
            held_d    = {1'b0, key_idx};
          end
        end else begin
          held_d = NO_KEY;
          if (key_up != KEY_UP_ONLY) begin
            has_res      = 1'b1;
            cmd.kind     = KIND_REL;
            cmd.width    = width_in;
            first_d      = 1'b1;
            cmd.two_res  = (held_q < NO_KEY);
            cmd.rel_slot = held_q[SLOT_W-1:0];
          end else if (held_q < NO_KEY) begin
            has_res  = 1'b1;
            cmd.kind = KIND_KEY;
            cmd.slot = held_q[SLOT_W-1:0];
          end
        end
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
  end

  assign q_push_o = accept && has_res;
  assign q_cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_mode_q <= 1'b0;
      move_thr_q <= COORD_W'(1);
      first_q    <= 1'b1;
      prev_x_q   <= '0;
      prev_y_q   <= '0;
      held_q     <= NO_KEY;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_KEY_MODE: key_mode_q <= cfg_wdata_i[0];
          CFG_MOVE_THR: move_thr_q <= cfg_wdata_i;
          default:      key_mode_q <= key_mode_q;
        endcase
      end
      if (accept) begin
        first_q  <= first_d;
        prev_x_q <= prev_x_d;
        prev_y_q <= prev_y_d;
        held_q   <= held_d;
      end
    end
  end

endmodule

### hdl/tred_queue.sv
// ----------------------------------------------------------------------------
// tred_queue
// Small command queue between the decode front and the result back end.
// ----------------------------------------------------------------------------
module tred_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tred_pkg::tred_cmd_t push_cmd_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output tred_pkg::tred_cmd_t head_o
);
  import tred_pkg::*;

  localparam int AW = $clog2(DEPTH);

  tred_cmd_t       mem_q [DEPTH];
  logic [AW:0]     wr_ptr_q, rd_ptr_q;

  assign empty_o = (wr_ptr_q == rd_ptr_q);
  assign full_o  = (wr_ptr_q[AW] != rd_ptr_q[AW]) &&
                   (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]);
  assign head_o  = mem_q[rd_ptr_q[AW-1:0]];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_ptr_q[AW-1:0]] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i && !empty_o) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

### hdl/tred_back.sv
// ----------------------------------------------------------------------------
// tred_back
// Expands queued commands into one or two result requests on the output.
// ----------------------------------------------------------------------------
module tred_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_empty_i,
  input  tred_pkg::tred_cmd_t               q_head_i,
  output logic                              q_pop_o,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [tred_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic [1:0]                        m_axis_tuser,
  output logic                              m_axis_tlast
);
  import tred_pkg::*;

  logic                  valid_q;
  logic                  second_q;
  logic                  load;
  logic [OUT_DATA_W-1:0] data_q, data_d;
  logic [1:0]            user_q, user_d;
  logic                  last_q, last_d;

  assign load    = !q_empty_i && (!valid_q || m_axis_tready);
  assign q_pop_o = load && (second_q || !q_head_i.two_res);

  always_comb begin
    if (second_q) begin
      data_d = {2'b00, q_head_i.rel_slot, 28'd0};
      user_d = KIND_KEY;
      last_d = 1'b1;
    end else begin
      data_d = {q_head_i.level, q_head_i.slot, q_head_i.width,
                q_head_i.pos_y, q_head_i.pos_x};
      user_d = q_head_i.kind;
      last_d = !q_head_i.two_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
      user_q <= user_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q  <= 1'b1;
        second_q <= !second_q && q_head_i.two_res;
      end else if (m_axis_tready) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = user_q;
  assign m_axis_tlast  = last_q;

endmodule

### hdl/touch_report_event_decoder.sv
// ----------------------------------------------------------------------------
// touch_report_event_decoder
// Decodes touch controller register frames into position, release and key
// events, with move filtering and touch-key handling.
// ----------------------------------------------------------------------------
// a result passes through the command queue and then the output register
// throughput: one frame per cycle while the queue is not full; a frame with two
// results occupies the single output register for each result in turn
// reset: first contact pending, last position 0, no key held, key mode off,
// move threshold 1; queue and output register empty
module touch_report_event_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tred_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tred_pkg::COORD_W-1:0]      cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // status_byte, x_high, x_low, y_high, y_low, contact_width, key_byte
  input  logic [tred_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // pos_x, pos_y, width_out, key_slot, key_level
  output logic [tred_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // event_kind
  output logic [1:0]                        m_axis_tuser,
  output logic                              m_axis_tlast
);
  import tred_pkg::*;

  logic      q_full, q_push, q_pop, q_empty;
  tred_cmd_t q_cmd, q_head;

  tred_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (q_cmd)
  );

  tred_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (q_head)
  );

  tred_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_pos_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_POS |-> m_axis_tlast &&
    m_axis_tdata[31:28] == 4'd0)
    else $error("position event not a single clean result");

  a_key_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_KEY |-> m_axis_tdata[27:0] == 28'd0)
    else $error("key event carries position or width");

  a_rel_then_key : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_REL && !m_axis_tlast
    |=> m_axis_tvalid && m_axis_tuser == KIND_KEY && m_axis_tlast)
    else $error("touch release not followed by key release");

endmodule
